[hdl/gpcfs_pkg.sv]
package gpcfs_pkg;

    // Sizes of the per-GPU state and of the frequency table
    localparam int NUM_GPUS    = 8;
    localparam int GPU_W       = $clog2(NUM_GPUS);
    localparam int MAX_PSTATES = 64;
    localparam int IDX_W       = $clog2(MAX_PSTATES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = GPU_W + IDX_W;
    localparam int TAB_DEPTH   = NUM_GPUS * MAX_PSTATES;

    // Payload field widths
    localparam int FREQ_W = 16;
    localparam int PWR_W  = 12;
    localparam int UTIL_W = 7;

    // Idle tick counter: advances by IDLE_STEP, wraps at IDLE_WRAP
    localparam int IDLE_STEP   = 10;
    localparam int IDLE_WRAP   = 50;
    localparam int IDLE_PHASES = IDLE_WRAP / IDLE_STEP;
    localparam int IDLE_W      = $clog2(IDLE_PHASES);

    // Step size rules
    localparam int EXCESS_MIN = 2;
    localparam int HEAD_MIN   = 5;
    localparam int STEP_SLACK = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPPING_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MODE    = 1'd1;

    // Item operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [GPU_W-1:0]  gpu;
        logic [IDX_W-1:0]  entry_index;
        logic [FREQ_W-1:0] entry_freq;
        logic              entry_last;
        logic [PWR_W-1:0]  power_measured;
        logic [PWR_W-1:0]  power_cap;
        logic [FREQ_W-1:0] freq_current;
        logic [FREQ_W-1:0] freq_target;
        logic [UTIL_W-1:0] util;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_new;
        logic              freq_valid;
        logic              reduced;
        logic              req_default;
    } t_out_item;

endpackage

[hdl/gpcfs_ifs.sv]
interface gpcfs_in_if import gpcfs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gpcfs_out_if import gpcfs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/gpu_power_cap_freq_stepper_top.sv]
// A load or an ignored tick goes straight to the result; an idle tick first reads the
// first and last table entries, a busy tick also scans its n entries (at most 64).
// Throughput: one transaction at a time; the next input is taken once the result
// sits in the output register; the linear search over the table memory's single
// read port, one entry per cycle, sets the tick time.
// Reset: synchronous, active low; clears per-GPU state and registers, not the table.
module gpu_power_cap_freq_stepper_top import gpcfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gpcfs_in_if.sink              i_in,
    gpcfs_out_if.source           o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_PREP  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_FETCH = 4'd6;
    localparam logic [3:0] S_FWAIT = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]        r_state;
    logic              r_cap_en;
    logic              r_release;

    // Per-GPU state
    logic [CNT_W-1:0]  r_cnt   [NUM_GPUS];
    logic [IDLE_W-1:0] r_idle  [NUM_GPUS];
    logic [FREQ_W-1:0] r_saved [NUM_GPUS];
    logic [FREQ_W-1:0] r_last  [NUM_GPUS];

    // Table memory
    logic [FREQ_W-1:0] r_mem [TAB_DEPTH];
    logic [FREQ_W-1:0] r_rdata;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_we;

    // Captured tick and working registers
    logic [GPU_W-1:0]  r_gpu;
    logic [PWR_W-1:0]  r_pm;
    logic [PWR_W-1:0]  r_cap;
    logic [FREQ_W-1:0] r_fcur;
    logic [FREQ_W-1:0] r_ftgt;
    logic              r_idle_tick;
    logic [CNT_W-1:0]  r_n;
    logic [FREQ_W-1:0] r_tab0;
    logic [FREQ_W-1:0] r_tabl;
    logic [FREQ_W-1:0] r_t;
    logic [FREQ_W-1:0] r_c;
    logic [FREQ_W-1:0] r_nf;
    logic [PWR_W-1:0]  r_steps;
    logic              r_down;
    logic              r_up;
    logic              r_red;
    logic              r_ask;
    logic [CNT_W-1:0]  r_scan_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_k;
    t_out_item         r_res;
    t_out_item         r_out;
    logic              r_out_valid;

    logic              w_in_fire;
    logic              w_out_fire;
    logic [CNT_W-1:0]  w_n_m1;
    logic [FREQ_W-1:0] w_t;
    logic [FREQ_W-1:0] n_c;
    logic [PWR_W-1:0]  w_excess;
    logic [PWR_W-1:0]  w_head;
    logic [PWR_W:0]    w_sum;
    logic [IDX_W-1:0]  w_k;
    logic [FREQ_W-1:0] w_nf;
    logic              w_ask;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_n_m1   = r_n - 1'b1;
    assign w_t      = (r_ftgt != '0) ? r_ftgt : r_tab0;
    assign w_excess = r_pm - r_cap;
    assign w_head   = r_cap - r_pm;

    // Current frequency: a saved one wins, then clip to the target
    always_comb begin
        n_c = (r_saved[r_gpu] != '0) ? r_saved[r_gpu] : r_fcur;
        if (w_t != '0 && n_c > w_t) begin
            n_c = w_t;
        end
    end

    // Destination entry once the current frequency is found
    always_comb begin
        w_sum = {{(PWR_W + 1 - IDX_W){1'b0}}, r_cmp_idx} + {1'b0, r_steps};
        if (r_down) begin
            if (w_sum > {{(PWR_W + 1 - CNT_W){1'b0}}, w_n_m1}) begin
                w_k = w_n_m1[IDX_W-1:0];
            end else begin
                w_k = w_sum[IDX_W-1:0];
            end
        end else begin
            if ({{(PWR_W - IDX_W){1'b0}}, r_cmp_idx} > r_steps) begin
                w_k = r_cmp_idx - r_steps[IDX_W-1:0];
            end else begin
                w_k = '0;
            end
        end
    end

    // Final clip to the target on a step up
    always_comb begin
        w_nf  = r_nf;
        w_ask = r_ask;
        if (r_up) begin
            if (r_nf > r_t) begin
                w_nf = r_t;
            end
            w_ask = r_release && (w_nf < r_t);
        end
    end

    // Table read address per sequencer step
    always_comb begin
        w_we = w_in_fire && (i_in.data.operation == OP_LOAD);
        unique case (r_state)
            S_RDL:   w_raddr = {r_gpu, w_n_m1[IDX_W-1:0]};
            S_SCAN:  w_raddr = {r_gpu, r_scan_idx[IDX_W-1:0]};
            S_FETCH: w_raddr = {r_gpu, r_k};
            default: w_raddr = {r_gpu, {IDX_W{1'b0}}};
        endcase
    end

    // Table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[{i_in.data.gpu, i_in.data.entry_index}] <= i_in.data.entry_freq;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en  <= 1'b0;
            r_release <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPPING_ENABLED: r_cap_en  <= i_cfg_data[0];
                CFG_RELEASE_MODE:    r_release <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_GPUS; i++) begin
                r_cnt[i]   <= '0;
                r_idle[i]  <= '0;
                r_saved[i] <= '0;
                r_last[i]  <= '0;
            end
        end else begin
            // drop the output once taken; the done state reloads it itself
            if (w_out_fire && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_gpu       <= i_in.data.gpu;
                        r_pm        <= i_in.data.power_measured;
                        r_cap       <= i_in.data.power_cap;
                        r_fcur      <= i_in.data.freq_current;
                        r_ftgt      <= i_in.data.freq_target;
                        r_idle_tick <= (i_in.data.util == '0);
                        r_n         <= r_cnt[i_in.data.gpu];
                        if (i_in.data.operation == OP_LOAD) begin
                            if (i_in.data.entry_last) begin
                                r_cnt[i_in.data.gpu] <= {1'b0, i_in.data.entry_index} + 1'b1;
                            end
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else if (!r_cap_en || r_cnt[i_in.data.gpu] == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_RDL;
                end
                S_RDL: begin
                    r_tab0  <= r_rdata;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_tabl <= r_rdata;
                    if (r_idle_tick) begin
                        // advance the idle count, drop to the lowest entry on wrap
                        if (r_idle[r_gpu] == IDLE_W'(IDLE_PHASES - 1)) begin
                            r_idle[r_gpu] <= '0;
                            if (r_fcur > r_saved[r_gpu]) begin
                                r_saved[r_gpu] <= r_fcur;
                            end
                            r_last[r_gpu]     <= r_rdata;
                            r_res.freq_new    <= r_rdata;
                        end else begin
                            r_idle[r_gpu]     <= r_idle[r_gpu] + 1'b1;
                            r_res.freq_new    <= r_last[r_gpu];
                        end
                        r_res.freq_valid  <= 1'b1;
                        r_res.reduced     <= 1'b0;
                        r_res.req_default <= 1'b0;
                        r_state           <= S_DONE;
                    end else begin
                        r_t            <= w_t;
                        r_c            <= n_c;
                        r_saved[r_gpu] <= '0;
                        r_state        <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_up       <= 1'b0;
                    r_red      <= 1'b0;
                    r_ask      <= 1'b0;
                    r_down     <= 1'b0;
                    r_cmp_vld  <= 1'b0;
                    r_scan_idx <= '0;
                    if (r_pm > r_cap) begin
                        // over the cap: step down
                        r_down  <= 1'b1;
                        r_red   <= 1'b1;
                        r_ask   <= r_release;
                        r_steps <= (w_excess > PWR_W'(EXCESS_MIN)) ?
                                   w_excess - PWR_W'(STEP_SLACK) : PWR_W'(1);
                        if (r_c == r_tabl) begin
                            r_nf    <= r_c;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else if (r_c < r_t) begin
                        // headroom and below target: step up
                        r_up    <= 1'b1;
                        r_steps <= (w_head > PWR_W'(HEAD_MIN)) ?
                                   w_head - PWR_W'(STEP_SLACK) : PWR_W'(1);
                        if (r_c == r_tab0) begin
                            r_nf    <= r_c;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_nf    <= r_c;
                        r_state <= S_FIN;
                    end
                end
                S_SCAN: begin
                    // issue one address, compare the previous read
                    r_scan_idx <= r_scan_idx + 1'b1;
                    r_cmp_idx  <= r_scan_idx[IDX_W-1:0];
                    r_cmp_vld  <= 1'b1;
                    if (r_cmp_vld && r_rdata == r_c) begin
                        r_k     <= w_k;
                        r_state <= S_FETCH;
                    end else if (r_cmp_vld && {1'b0, r_cmp_idx} == w_n_m1) begin
                        r_nf    <= r_down ? r_tabl : r_tab0;
                        r_state <= S_FIN;
                    end
                end
                S_FETCH: begin
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    r_nf    <= r_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_last[r_gpu]     <= w_nf;
                    r_res.freq_new    <= w_nf;
                    r_res.freq_valid  <= 1'b1;
                    r_res.reduced     <= r_red;
                    r_res.req_default <= w_ask;
                    r_state           <= S_DONE;
                end
                S_DONE: begin
                    // hand the result to the output register when it is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !i_in.ready)
        else $error("input taken again right after a transaction");

    a_fetch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> ({1'b0, r_k} < r_n))
        else $error("table fetch beyond the entry count");

    a_reduced_has_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.reduced) |-> o_out.data.freq_valid)
        else $error("reduced flagged without a frequency");

    a_ask_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.req_default) |-> r_release)
        else $error("default cap requested outside release mode");

    a_no_freq_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.freq_valid) |-> (o_out.data.freq_new == '0))
        else $error("frequency given on a result without one");

endmodule

[tb/tb_gpu_power_cap_freq_stepper_top.sv]
module tb_gpu_power_cap_freq_stepper_top;
    import gpcfs_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gpcfs_in_if  in_if ();
    gpcfs_out_if out_if ();

    gpu_power_cap_freq_stepper_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Shadow of the per-GPU state and the registers
    logic [FREQ_W-1:0]      ftab [NUM_GPUS][MAX_PSTATES];
    int unsigned            tab_len [NUM_GPUS];
    int unsigned            idle_cnt [NUM_GPUS];
    logic [FREQ_W-1:0]      saved_f [NUM_GPUS];
    logic [FREQ_W-1:0]      last_f [NUM_GPUS];
    bit                     cap_en;
    bit                     rel_mode;

    // Table entries written so far; a table is only closed over written entries
    logic [MAX_PSTATES-1:0] loaded [NUM_GPUS];

    t_out_item pending_limits [$];
    int        mismatches;
    int        items_sent;
    bit        src_gaps;
    bit        snk_stalls;
    int        hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb_gpu_power_cap_freq_stepper_top: done, errors");
        $finish;
    end

    // First table position holding f, or n when absent
    function automatic int unsigned table_pos(int unsigned g, int unsigned n,
                                              int unsigned f);
        int unsigned j;
        for (j = 0; j < n; j++)
            if (ftab[g][j] == f) return j;
        return n;
    endfunction

    // Compute the result of one transaction and advance the shadow state
    function automatic t_out_item next_freq_limit(t_in_item it);
        t_out_item   r;
        int unsigned g, n, t, c, nf, excess, steps, j, k;
        r = '0;
        g = it.gpu;
        if (it.operation == OP_LOAD) begin
            ftab[g][it.entry_index] = it.entry_freq;
            if (it.entry_last) tab_len[g] = it.entry_index + 1;
            return r;
        end
        n = tab_len[g];
        if (!cap_en || n == 0) return r;
        t = (it.freq_target != 0) ? it.freq_target : ftab[g][0];
        r.freq_valid = 1'b1;

        // Idle: count ticks, drop to the lowest entry on every fifth one
        if (it.util == 0) begin
            idle_cnt[g] = (idle_cnt[g] + IDLE_STEP) % IDLE_WRAP;
            if (idle_cnt[g] == 0) begin
                if (it.freq_current > saved_f[g]) saved_f[g] = it.freq_current;
                last_f[g] = ftab[g][n-1];
            end
            r.freq_new = last_f[g];
            return r;
        end

        // Busy: restore the saved frequency, clip to the target
        c = it.freq_current;
        if (saved_f[g] != 0) begin
            c = saved_f[g];
            saved_f[g] = '0;
        end
        if (t > 0 && c > t) c = t;
        nf = c;

        if (it.power_measured > it.power_cap) begin
            excess = it.power_measured - it.power_cap;
            steps  = (excess > EXCESS_MIN) ? excess - STEP_SLACK : 1;
            r.reduced     = 1'b1;
            r.req_default = rel_mode;
            if (c != ftab[g][n-1]) begin
                j = table_pos(g, n, c);
                if (j >= n) begin
                    nf = ftab[g][n-1];
                end else begin
                    k = j + steps;
                    if (k > n - 1) k = n - 1;
                    nf = ftab[g][k];
                end
            end
        end else if (c < t && t > 0) begin
            steps = it.power_cap - it.power_measured;
            steps = (steps > HEAD_MIN) ? steps - STEP_SLACK : 1;
            if (c != ftab[g][0]) begin
                j  = table_pos(g, n, c);
                nf = (j >= n) ? ftab[g][0] : ftab[g][(j > steps) ? j - steps : 0];
            end
            if (nf > t) nf = t;
            r.req_default = rel_mode && (nf < t);
        end

        last_f[g]  = FREQ_W'(nf);
        r.freq_new = FREQ_W'(nf);
        return r;
    endfunction

    // Random filler for the fields an item does not use
    function automatic t_in_item random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input t_in_item it);
        int gap;
        gap = src_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_limits.push_back(next_freq_limit(it));
        items_sent++;
    endtask

    task automatic load_entry(input int g, input int idx, input int f, input bit last);
        t_in_item it;
        it = random_item();
        it.operation   = OP_LOAD;
        it.gpu         = GPU_W'(g);
        it.entry_index = IDX_W'(idx);
        it.entry_freq  = FREQ_W'(f);
        it.entry_last  = last;
        loaded[g][idx] = 1'b1;
        send_item(it);
    endtask

    task automatic send_tick(input int g, input int pm, input int cap, input int cur,
                             input int tgt, input int u);
        t_in_item it;
        it = random_item();
        it.operation      = OP_TICK;
        it.gpu            = GPU_W'(g);
        it.power_measured = PWR_W'(pm);
        it.power_cap      = PWR_W'(cap);
        it.freq_current   = FREQ_W'(cur);
        it.freq_target    = FREQ_W'(tgt);
        it.util           = UTIL_W'(u);
        send_item(it);
    endtask

    // Stop offering, wait out every pending result and the tail latency
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_limits.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input bit v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_CAPPING_ENABLED) cap_en = v;
        else rel_mode = v;
    endtask

    // Fill entries 0..len-1, mostly descending, and close the table
    task automatic load_table(input int g, input int len);
        int j, f;
        bit scramble;
        scramble = ($urandom_range(0, 9) == 0);
        f = $urandom_range(1000, 65535);
        for (j = 0; j < len; j++) begin
            if (scramble) f = $urandom_range(0, 65535);
            load_entry(g, j, f, j == len - 1);
            if (!scramble && f > 600) f = f - $urandom_range(0, 600);
        end
    endtask

    task automatic check_field(input string name, input logic [FREQ_W-1:0] want,
                               input logic [FREQ_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_limits.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
            want = pending_limits.pop_front();
            check_field("freq_new", want.freq_new, got.freq_new);
            check_field("freq_valid", want.freq_valid, got.freq_valid);
            check_field("reduced", want.reduced, got.reduced);
            check_field("req_default", want.req_default, got.req_default);
        end
    endtask

    // Accept results with random stalls, or one long hold when requested
    initial begin : result_sink
        int stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = snk_stalls ? $urandom_range(0, 15) : 0;
            if (hold_req != 0) begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            check_result(out_if.data);
        end
    end

    task automatic send_random_load();
        int g, idx;
        logic [MAX_PSTATES-1:0] low;
        g   = $urandom_range(0, NUM_GPUS - 1);
        idx = $urandom_range(0, 1) ? $urandom_range(0, MAX_PSTATES - 1) : $urandom_range(0, 7);
        low = '1;
        low = low >> (MAX_PSTATES - 1 - idx);
        // close the table here only if every entry below is written
        load_entry(g, idx, $urandom_range(0, 65535),
                   (((loaded[g] | low & ~(low >> 1)) & low) == low) && $urandom_range(0, 1));
    endtask

    task automatic send_random_tick();
        int g, tries, cap, pm, cur, tgt, u, sel;
        g = $urandom_range(0, NUM_GPUS - 1);
        tries = 0;
        if ($urandom_range(0, 9) != 0)
            while (tab_len[g] == 0 && tries < 8) begin
                g = $urandom_range(0, NUM_GPUS - 1);
                tries++;
            end

        // Power mostly near the cap, so small excess and headroom dominate
        cap = $urandom_range(0, 4095);
        sel = $urandom_range(0, 9);
        if (sel < 3) pm = cap + $urandom_range(1, 6);
        else if (sel < 6) pm = cap - $urandom_range(0, 12);
        else if (sel == 6) pm = cap;
        else pm = $urandom_range(0, 4095);
        if (pm > 4095) pm = 4095;
        if (pm < 0) pm = 0;

        sel = $urandom_range(0, 9);
        if (sel < 2 || tab_len[g] == 0) cur = $urandom_range(0, 65535);
        else cur = ftab[g][$urandom_range(0, tab_len[g] - 1)];

        sel = $urandom_range(0, 7);
        if (sel < 2) tgt = 0;
        else if (sel < 4 || tab_len[g] == 0) tgt = $urandom_range(0, 65535);
        else tgt = ftab[g][$urandom_range(0, tab_len[g] - 1)];

        sel = $urandom_range(0, 19);
        if (sel < 6) u = 0;
        else if (sel == 6) u = 100;
        else u = $urandom_range(1, 99);

        send_tick(g, pm, cap, cur, tgt, u);
    endtask

    // Reset state: ticks give nothing while capping is off or a table is empty
    task automatic test_disabled_and_empty();
        int j;
        for (j = 0; j < 4; j++) load_entry(0, j, 2000 - 500 * j, j == 3);
        send_tick(0, 200, 100, 1500, 0, 50);
        load_entry(7, MAX_PSTATES - 1, 16'hFFFF, 1'b0);
        write_cfg(CFG_CAPPING_ENABLED, 1'b1);
        send_tick(5, 4095, 0, 16'hFFFF, 16'hFFFF, 100);
    endtask

    // Idle: repeat the last limit, drop on the fifth tick, restore when busy
    task automatic test_idle_drop();
        int j;
        for (j = 0; j < 5; j++) send_tick(0, 100, 100, 1800, 0, 0);
        send_tick(0, 100, 100, 500, 1600, 50);
        send_tick(0, 100, 100, 1600, 0, 0);
    endtask

    // Over the cap: excess of one and two watts, larger steps, absent freq
    task automatic test_step_down();
        send_tick(0, 101, 100, 1500, 0, 100);
        send_tick(0, 102, 100, 1500, 0, 100);
        send_tick(0, 104, 100, 2000, 0, 100);
        send_tick(0, 4095, 0, 2000, 0, 100);
        send_tick(0, 200, 100, 1234, 0, 100);
        send_tick(0, 101, 100, 500, 0, 100);
    endtask

    // Under the cap: small headroom, large headroom, absent freq, target clip
    task automatic test_step_up();
        send_tick(0, 95, 100, 1000, 0, 1);
        send_tick(0, 92, 100, 500, 0, 1);
        send_tick(0, 0, 4095, 1234, 1700, 1);
        send_tick(0, 10, 100, 2000, 1000, 1);
    endtask

    // Release mode: ask for the default cap when over it or short of target
    task automatic test_release();
        write_cfg(CFG_RELEASE_MODE, 1'b1);
        send_tick(0, 103, 100, 1000, 0, 64);
        send_tick(0, 99, 100, 500, 1800, 64);
        send_tick(0, 0, 4095, 500, 1500, 64);
    endtask

    task automatic test_random_phase(input bit cap, input bit rel, input int n,
                                     input int first_len);
        int stop, sel;
        write_cfg(CFG_CAPPING_ENABLED, cap);
        write_cfg(CFG_RELEASE_MODE, rel);
        load_table($urandom_range(0, NUM_GPUS - 1), first_len);
        stop = items_sent + n;
        while (items_sent < stop) begin
            // switch idling on and off in stretches
            if ($urandom_range(0, 49) == 0) begin
                src_gaps   = ($urandom_range(0, 9) < 7);
                snk_stalls = ($urandom_range(0, 9) < 7);
            end
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                sel = $urandom_range(0, 19);
                if (sel < 15) load_table($urandom_range(0, NUM_GPUS - 1), $urandom_range(1, 8));
                else if (sel < 19)
                    load_table($urandom_range(0, NUM_GPUS - 1), $urandom_range(9, 32));
                else load_table($urandom_range(0, NUM_GPUS - 1), $urandom_range(33, 64));
            end else if (sel < 9) begin
                send_random_load();
            end else begin
                send_random_tick();
            end
        end
        src_gaps   = 1'b1;
        snk_stalls = 1'b1;
    endtask

    // Hold the result side for a long stretch while items keep coming
    task automatic test_backpressure();
        int j;
        drain();
        hold_req = 400;
        src_gaps = 1'b0;
        for (j = 0; j < 40; j++) send_random_tick();
        src_gaps = 1'b1;
        drain();
    endtask

    initial begin : stimulus
        int g;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        for (g = 0; g < NUM_GPUS; g++) begin
            tab_len[g]  = 0;
            idle_cnt[g] = 0;
            saved_f[g]  = '0;
            last_f[g]   = '0;
            loaded[g]   = '0;
            for (int j = 0; j < MAX_PSTATES; j++) ftab[g][j] = '0;
        end
        cap_en     = 1'b0;
        rel_mode   = 1'b0;
        mismatches = 0;
        items_sent = 0;
        src_gaps   = 1'b1;
        snk_stalls = 1'b1;
        hold_req   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_and_empty();
        test_idle_drop();
        test_step_down();
        test_step_up();
        test_release();
        test_random_phase(1'b1, 1'b0, 300, MAX_PSTATES);
        test_random_phase(1'b1, 1'b1, 300, 8);
        test_random_phase(1'b0, 1'b1, 80, 4);
        test_random_phase(1'b0, 1'b0, 80, 2);
        write_cfg(CFG_CAPPING_ENABLED, 1'b1);
        test_backpressure();
        test_random_phase(1'b1, 1'b0, 300, 1);
        test_random_phase(1'b1, 1'b1, 300, MAX_PSTATES);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_limits.size() == 0) begin
            $display("tb_gpu_power_cap_freq_stepper_top: done, clean");
        end else begin
            $display("tb_gpu_power_cap_freq_stepper_top: done, errors");
        end
        $finish;
    end

endmodule
